[rtl/core/sfp_pkg.sv]
`default_nettype none

package sfp_pkg;

  // Default capacity of the id table (servos per frame)
  localparam int MAX_ENTRIES_DEF = 8;

  // Flags byte fields
  localparam logic [7:0] KIND_MASK    = 8'b0010_0000;
  localparam logic [7:0] BLOCKED_MASK = 8'b0001_0000;
  localparam logic [7:0] MODE_MASK    = 8'b0000_1000;
  localparam logic [7:0] COLOR_MASK   = 8'b0000_0111;

  // Byte positions inside a 6-byte record
  localparam logic [2:0] POS_ID      = 3'd0;
  localparam logic [2:0] POS_POS_HI  = 3'd1;
  localparam logic [2:0] POS_POS_LO  = 3'd2;
  localparam logic [2:0] POS_CMD_HI  = 3'd3;
  localparam logic [2:0] POS_CMD_LO  = 3'd4;
  localparam logic [2:0] POS_FLAGS   = 3'd5;

  // Result queue: room for two results from one byte plus slack
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  // One result word
  typedef struct packed {
    logic        record_valid;
    logic [7:0]  servo_id;
    logic [15:0] servo_position;
    logic [15:0] servo_command;
    logic        command_kind;
    logic        is_blocked;
    logic        block_mode;
    logic [2:0]  servo_color;
    logic        frame_done;
    logic        parse_failed;
    logic [7:0]  servo_total;
  } sfp_result_t;

endpackage

`default_nettype wire

[rtl/core/sfp_byte_if.sv]
`default_nettype none

interface sfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/core/sfp_result_if.sv]
`default_nettype none

interface sfp_result_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [7:0]  servo_id;
  logic [15:0] servo_position;
  logic [15:0] servo_command;
  logic        command_kind;
  logic        is_blocked;
  logic        block_mode;
  logic [2:0]  servo_color;
  logic        frame_done;
  logic        parse_failed;
  logic [7:0]  servo_total;

  modport source (
    output valid, output record_valid, output servo_id, output servo_position,
    output servo_command, output command_kind, output is_blocked, output block_mode,
    output servo_color, output frame_done, output parse_failed, output servo_total,
    input ready
  );
  modport sink (
    input valid, input record_valid, input servo_id, input servo_position,
    input servo_command, input command_kind, input is_blocked, input block_mode,
    input servo_color, input frame_done, input parse_failed, input servo_total,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/servo_frame_parser.sv]
`default_nettype none

// Channel   Dir  Word
// frame     in   frame_byte[7:0], end_of_frame
// result    out  record or end-of-frame status (record_valid / frame_done)
//
// One byte is accepted per cycle while frame is ready; its results are written
// into a 4-entry result queue in the same edge and leave one per cycle while
// result is ready. A byte that completes a record and ends the frame yields
// two results, so it takes two queue entries; frame is ready while the queue
// has room for two results.
// Reset (rst, synchronous) empties the queue and waits for a header byte.
// A stall on result backs up into the queue and then holds frame.ready low.

module servo_frame_parser
  import sfp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  sfp_byte_if.sink      frame,
  sfp_result_if.source  result
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Parser state
  logic                   at_frame_start, at_frame_start_next;
  logic [7:0]             expected_count, expected_count_next;
  logic [7:0]             records_done, records_done_next;
  logic [2:0]             byte_in_record, byte_in_record_next;
  logic [7:0]             partial_id, partial_id_next;
  logic [15:0]            partial_position, partial_position_next;
  logic [15:0]            partial_command, partial_command_next;
  logic [MAX_ENTRIES-1:0] seen_valid, seen_valid_next;
  logic                   failed_flag, failed_flag_next;
  logic [7:0]             seen_ids [MAX_ENTRIES];

  // Result queue
  sfp_result_t            rq [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]    rq_wr, rq_rd;
  logic [RQ_PTR_W:0]      rq_count;

  logic        accept, pop;
  logic        emit, last, id_hit, seen_write;
  sfp_result_t rec_word, stat_word;
  logic [1:0]  push_n;

  assign accept = frame.valid && frame.ready;
  assign pop    = result.valid && result.ready;
  assign last   = accept && frame.end_of_frame;

  // Keep room for the two results one byte may produce
  assign frame.ready = (rq_count <= (RQ_PTR_W + 1)'(RQ_DEPTH - 2));

  // Match the id against every recorded entry at once
  always_comb begin
    id_hit = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (seen_valid[i] && (seen_ids[i] == frame.frame_byte)) begin
        id_hit = 1'b1;
      end
    end
  end

  // Decode one byte: next state and result words
  always_comb begin
    at_frame_start_next   = at_frame_start;
    expected_count_next   = expected_count;
    records_done_next     = records_done;
    byte_in_record_next   = byte_in_record;
    partial_id_next       = partial_id;
    partial_position_next = partial_position;
    partial_command_next  = partial_command;
    seen_valid_next       = seen_valid;
    failed_flag_next      = failed_flag;
    emit                  = 1'b0;
    seen_write            = 1'b0;
    rec_word              = '0;
    stat_word             = '0;

    if (accept) begin
      if (at_frame_start) begin
        at_frame_start_next = 1'b0;
        expected_count_next = frame.frame_byte;
        records_done_next   = '0;
        byte_in_record_next = POS_ID;
        seen_valid_next     = '0;
        failed_flag_next    = (frame.frame_byte > 8'(MAX_ENTRIES));
      end else if (!failed_flag) begin
        if (records_done >= expected_count) begin
          failed_flag_next = 1'b1;
        end else begin
          case (byte_in_record)
            POS_ID: begin
              if ((frame.frame_byte == 8'd0) || id_hit) begin
                failed_flag_next = 1'b1;
              end else begin
                partial_id_next     = frame.frame_byte;
                byte_in_record_next = POS_POS_HI;
              end
            end
            POS_POS_HI: begin
              partial_position_next = {frame.frame_byte, 8'd0};
              byte_in_record_next   = POS_POS_LO;
            end
            POS_POS_LO: begin
              partial_position_next = {partial_position[15:8], frame.frame_byte};
              byte_in_record_next   = POS_CMD_HI;
            end
            POS_CMD_HI: begin
              partial_command_next = {frame.frame_byte, 8'd0};
              byte_in_record_next  = POS_CMD_LO;
            end
            POS_CMD_LO: begin
              partial_command_next = {partial_command[15:8], frame.frame_byte};
              byte_in_record_next  = POS_FLAGS;
            end
            default: begin
              emit                    = 1'b1;
              rec_word.record_valid   = 1'b1;
              rec_word.servo_id       = partial_id;
              rec_word.servo_position = partial_position;
              rec_word.servo_command  = partial_command;
              rec_word.command_kind   = |(frame.frame_byte & KIND_MASK);
              rec_word.is_blocked     = |(frame.frame_byte & BLOCKED_MASK);
              rec_word.block_mode     = |(frame.frame_byte & MODE_MASK);
              rec_word.servo_color    = 3'(frame.frame_byte & COLOR_MASK);
              if (records_done < 8'(MAX_ENTRIES)) begin
                seen_write = 1'b1;
                seen_valid_next[records_done[IDX_W-1:0]] = 1'b1;
              end
              records_done_next   = records_done + 8'd1;
              byte_in_record_next = POS_ID;
            end
          endcase
        end
      end

      // Close the frame with a status word
      if (frame.end_of_frame) begin
        stat_word.frame_done   = 1'b1;
        stat_word.parse_failed = !(!failed_flag_next &&
                                   (records_done_next == expected_count_next) &&
                                   (byte_in_record_next == POS_ID));
        stat_word.servo_total  = expected_count_next;
        at_frame_start_next    = 1'b1;
      end
    end
  end

  assign push_n = {1'b0, emit} + {1'b0, last};

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      at_frame_start <= 1'b1;
      expected_count <= '0;
      records_done   <= '0;
      byte_in_record <= POS_ID;
      seen_valid     <= '0;
      failed_flag    <= 1'b0;
    end else begin
      at_frame_start <= at_frame_start_next;
      expected_count <= expected_count_next;
      records_done   <= records_done_next;
      byte_in_record <= byte_in_record_next;
      seen_valid     <= seen_valid_next;
      failed_flag    <= failed_flag_next;
    end
  end

  // Hold partial record bytes and the id table
  always_ff @(posedge clk) begin
    partial_id       <= partial_id_next;
    partial_position <= partial_position_next;
    partial_command  <= partial_command_next;
    if (seen_write) begin
      seen_ids[records_done[IDX_W-1:0]] <= partial_id;
    end
  end

  // Write result words into the queue
  always_ff @(posedge clk) begin
    if (emit) begin
      rq[rq_wr] <= rec_word;
      if (last) begin
        rq[rq_wr + RQ_PTR_W'(1)] <= stat_word;
      end
    end else if (last) begin
      rq[rq_wr] <= stat_word;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      rq_wr    <= rq_wr + RQ_PTR_W'(push_n);
      rq_rd    <= rq_rd + RQ_PTR_W'(pop);
      rq_count <= rq_count + (RQ_PTR_W + 1)'(push_n) - (RQ_PTR_W + 1)'(pop);
    end
  end

  // Drive the result channel from the queue head
  assign result.valid          = (rq_count != '0);
  assign result.record_valid   = rq[rq_rd].record_valid;
  assign result.servo_id       = rq[rq_rd].servo_id;
  assign result.servo_position = rq[rq_rd].servo_position;
  assign result.servo_command  = rq[rq_rd].servo_command;
  assign result.command_kind   = rq[rq_rd].command_kind;
  assign result.is_blocked     = rq[rq_rd].is_blocked;
  assign result.block_mode     = rq[rq_rd].block_mode;
  assign result.servo_color    = rq[rq_rd].servo_color;
  assign result.frame_done     = rq[rq_rd].frame_done;
  assign result.parse_failed   = rq[rq_rd].parse_failed;
  assign result.servo_total    = rq[rq_rd].servo_total;

  // Checks
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rq_count <= (RQ_PTR_W + 1)'(RQ_DEPTH))
    else $error("result queue overflow");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    last |=> at_frame_start)
    else $error("frame end did not return to header");

  a_record_pos: assert property (@(posedge clk) disable iff (rst)
    byte_in_record <= POS_FLAGS)
    else $error("record byte position out of range");

  a_records_bound: assert property (@(posedge clk) disable iff (rst)
    (!failed_flag && !at_frame_start) |-> (records_done <= expected_count))
    else $error("more records than header count");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |-> (rq_count <= (RQ_PTR_W + 1)'(RQ_DEPTH - 2)))
    else $error("two results pushed without room");

endmodule

`default_nettype wire

[tb/servo_frame_parser_tb.sv]
`default_nettype none

module servo_frame_parser_tb;
  import sfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_WORDS    = 1650;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_LIMIT   = 10;

  // Tracks the frame decode and holds the records and status words still due
  class frame_scoreboard;
    logic                       at_frame_start;
    logic [7:0]                 expected_count;
    logic [7:0]                 records_done;
    logic [2:0]                 byte_in_record;
    logic [7:0]                 partial_id;
    logic [15:0]                partial_position;
    logic [15:0]                partial_command;
    logic [7:0]                 seen_ids [MAX_ENTRIES_DEF];
    logic [MAX_ENTRIES_DEF-1:0] seen_valid;
    logic                       failed;
    sfp_result_t                due_results [$];
    int                         mismatches;

    function new();
      at_frame_start   = 1'b1;
      expected_count   = '0;
      records_done     = '0;
      byte_in_record   = '0;
      partial_id       = '0;
      partial_position = '0;
      partial_command  = '0;
      seen_valid       = '0;
      failed           = 1'b0;
      mismatches       = 0;
    endfunction

    function string show(sfp_result_t r);
      return $sformatf({"rec=%0b id=%02h pos=%04h cmd=%04h kind=%0b blk=%0b mode=%0b ",
                        "color=%0d done=%0b fail=%0b total=%0d"},
                       r.record_valid, r.servo_id, r.servo_position, r.servo_command,
                       r.command_kind, r.is_blocked, r.block_mode, r.servo_color,
                       r.frame_done, r.parse_failed, r.servo_total);
    endfunction

    function void note_failure(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Advance the decode by one accepted word and queue what it produces
    function void predict_byte(logic [7:0] b, logic eof);
      sfp_result_t rec;
      sfp_result_t status;
      logic        dup;

      rec = '0;
      if (at_frame_start) begin
        // Header word: load the count, reject it above the table size
        at_frame_start = 1'b0;
        expected_count = b;
        records_done   = '0;
        byte_in_record = '0;
        seen_valid     = '0;
        failed         = (b > MAX_ENTRIES_DEF);
      end else if (!failed) begin
        if (records_done >= expected_count) begin
          failed = 1'b1;
        end else begin
          case (byte_in_record)
            POS_ID: begin
              dup = 1'b0;
              for (int i = 0; i < MAX_ENTRIES_DEF; i++)
                if (seen_valid[i] && seen_ids[i] == b) dup = 1'b1;
              if (b == 8'h00 || dup) begin
                failed = 1'b1;
              end else begin
                partial_id     = b;
                byte_in_record = byte_in_record + 3'd1;
              end
            end
            POS_POS_HI: begin
              partial_position = {b, 8'h00};
              byte_in_record   = byte_in_record + 3'd1;
            end
            POS_POS_LO: begin
              partial_position[7:0] = b;
              byte_in_record        = byte_in_record + 3'd1;
            end
            POS_CMD_HI: begin
              partial_command = {b, 8'h00};
              byte_in_record  = byte_in_record + 3'd1;
            end
            POS_CMD_LO: begin
              partial_command[7:0] = b;
              byte_in_record       = byte_in_record + 3'd1;
            end
            default: begin
              // Flags word closes the record
              rec.record_valid   = 1'b1;
              rec.servo_id       = partial_id;
              rec.servo_position = partial_position;
              rec.servo_command  = partial_command;
              rec.command_kind   = (b & KIND_MASK) != 8'h00;
              rec.is_blocked     = (b & BLOCKED_MASK) != 8'h00;
              rec.block_mode     = (b & MODE_MASK) != 8'h00;
              rec.servo_color    = b[2:0] & COLOR_MASK[2:0];
              due_results.push_back(rec);
              if (records_done < MAX_ENTRIES_DEF) begin
                seen_ids[records_done]   = partial_id;
                seen_valid[records_done] = 1'b1;
              end
              records_done   = records_done + 8'd1;
              byte_in_record = '0;
            end
          endcase
        end
      end

      // Last word of the frame: queue the status word
      if (eof) begin
        status              = '0;
        status.frame_done   = 1'b1;
        status.parse_failed = !(!failed && records_done == expected_count &&
                                byte_in_record == 3'd0);
        status.servo_total  = expected_count;
        due_results.push_back(status);
        at_frame_start = 1'b1;
      end
    endfunction

    // Compare one accepted result word with the oldest one due
    function void compare_result(sfp_result_t got);
      sfp_result_t want;

      if (due_results.size() == 0) begin
        note_failure({"unexpected word ", show(got)});
        return;
      end
      want = due_results.pop_front();
      if (got.record_valid   !== want.record_valid   ||
          got.servo_id       !== want.servo_id       ||
          got.servo_position !== want.servo_position ||
          got.servo_command  !== want.servo_command  ||
          got.command_kind   !== want.command_kind   ||
          got.is_blocked     !== want.is_blocked     ||
          got.block_mode     !== want.block_mode     ||
          got.servo_color    !== want.servo_color    ||
          got.frame_done     !== want.frame_done     ||
          got.parse_failed   !== want.parse_failed   ||
          got.servo_total    !== want.servo_total)
        note_failure({"expected ", show(want), " got ", show(got)});
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Count every word still due as missing
    function void flush_missing();
      while (due_results.size() != 0)
        note_failure({"missing word ", show(due_results.pop_front())});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sfp_byte_if   frame_ch ();
  sfp_result_if result_ch ();

  servo_frame_parser dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch)
  );

  frame_scoreboard sb;
  logic [7:0]      frame_bytes [$];
  int              gap_pct;
  int              stall_pct;
  int              hold_req;
  int              words_sent;
  int              idle_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls plus long hold-offs on request
  initial begin
    int hold_ack;
    int hold_left;

    hold_ack        = 0;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.compare_result({result_ch.record_valid, result_ch.servo_id,
                         result_ch.servo_position, result_ch.servo_command,
                         result_ch.command_kind, result_ch.is_blocked,
                         result_ch.block_mode, result_ch.servo_color,
                         result_ch.frame_done, result_ch.parse_failed,
                         result_ch.servo_total});
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(input logic [7:0] b, input logic eof);
    while ($urandom_range(0, 99) < gap_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid        <= 1'b1;
    frame_ch.frame_byte   <= b;
    frame_ch.end_of_frame <= eof;
    do @(posedge clk); while (!frame_ch.ready);
    sb.predict_byte(b, eof);
    words_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drop valid and wait until every due result has come back
  task automatic wait_drained();
    frame_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; a quarter get broken
  function automatic void build_random_frame();
    int         n_rec;
    int         j;
    int         k;
    logic [7:0] ids [$];
    logic [7:0] id;
    logic       clash;

    frame_bytes.delete();
    n_rec = ($urandom_range(0, 3) == 0) ? MAX_ENTRIES_DEF : $urandom_range(0, MAX_ENTRIES_DEF);
    frame_bytes.push_back(8'(n_rec));
    for (j = 0; j < n_rec; j++) begin
      do begin
        id    = 8'($urandom_range(1, 255));
        clash = 1'b0;
        foreach (ids[m]) if (ids[m] == id) clash = 1'b1;
      end while (clash);
      ids.push_back(id);
      frame_bytes.push_back(id);
      repeat (5) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end

    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 5))
        0: begin
          // Cut the frame short, often inside a record
          if (frame_bytes.size() > 1)
            repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
        end
        1: repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        2: begin
          if (n_rec > 0) frame_bytes[1 + 6 * $urandom_range(0, n_rec - 1)] = 8'h00;
        end
        3: begin
          if (n_rec > 1) begin
            k = $urandom_range(1, n_rec - 1);
            j = $urandom_range(0, k - 1);
            frame_bytes[1 + 6 * k] = frame_bytes[1 + 6 * j];
          end
        end
        4: frame_bytes[0] = 8'($urandom_range(MAX_ENTRIES_DEF + 1, 255));
        default: begin
          frame_bytes.delete();
          repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  initial begin
    sb                     = new();
    gap_pct                = 0;
    stall_pct              = 0;
    hold_req               = 0;
    words_sent             = 0;
    rst                    = 1'b1;
    frame_ch.valid         = 1'b0;
    frame_ch.frame_byte    = '0;
    frame_ch.end_of_frame  = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: header-only frame, extreme record, repeated id, too many
    // servos, zero id, extra word and a frame missing its records
    frame_bytes = '{8'h00};
    send_frame();
    frame_bytes = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_frame();
    frame_bytes = '{8'h02, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h05};
    send_frame();
    frame_bytes = '{8'h09, 8'h03};
    send_frame();
    frame_bytes = '{8'h01, 8'h00};
    send_frame();
    frame_bytes = '{8'h00, 8'h07};
    send_frame();
    frame_bytes = '{8'h02};
    send_frame();

    // Random phases: no idling, sender idle, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 68; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 68; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      // Hold the result side off while words keep coming
      if (phase == 0 || phase == 2) hold_req++;
      while (words_sent < (phase + 1) * TOTAL_WORDS / 4) begin
        build_random_frame();
        send_frame();
      end
      // Pause the sender until every result is back
      wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_missing();
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
